>>> sv/wvtp_pkg.sv
`timescale 1ns / 1ps

package wvtp_pkg;

  localparam int MAX_VERTICES  = 16;
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;
  localparam int FRAC_BITS     = 16;

  // slot address bits (store depth is a power of two)
  localparam int IDX_W = $clog2(MAX_VERTICES);

  // clip parameter fraction bits
  localparam int T_BITS = 30;
  // quotient digits of a screen division, the sign bit makes the 16th
  localparam int PIX_Q = 15;
  // divider remainder width: 16*z < 2^35, doubled plus headroom
  localparam int REM_W = 38;
  // screen numerator width: 13*W*2^31 and H*2^32 both fit
  localparam int NUM_W = 34 + $clog2(13 * SCREEN_WIDTH + SCREEN_HEIGHT);

  localparam logic signed [31:0] NEAR_Z = 32'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic signed [31:0] W8     = 32'(8 * SCREEN_WIDTH);
  localparam logic signed [31:0] W5     = 32'(5 * SCREEN_WIDTH);
  localparam logic signed [31:0] HGT    = 32'(SCREEN_HEIGHT);

  // input kinds
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_EDGE   = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_OBJECT_COS = 3'd0;
  localparam logic [2:0] CFG_OBJECT_SIN = 3'd1;
  localparam logic [2:0] CFG_VIEW_COS   = 3'd2;
  localparam logic [2:0] CFG_VIEW_SIN   = 3'd3;
  localparam logic [2:0] CFG_OFFSET_X   = 3'd4;
  localparam logic [2:0] CFG_OFFSET_Y   = 3'd5;
  localparam logic [2:0] CFG_OFFSET_Z   = 3'd6;

  typedef logic signed [65:0] wide_t;

  localparam wide_t MAX32 = 66'sh7FFFFFFF;
  localparam wide_t MIN32 = -66'sh80000000;

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > MAX32) begin
      r = 32'sh7FFFFFFF;
    end else if (v < MIN32) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> sv/wvtp_mul.sv
`timescale 1ns / 1ps

module wvtp_mul (
  input  logic                clk,
  input  logic signed [32:0]  a,
  input  logic signed [31:0]  b,
  output logic signed [64:0]  p
);

  // one registered signed product per cycle
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> sv/wvtp_div.sv
`timescale 1ns / 1ps

module wvtp_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wvtp_pkg::REM_W-1:0]   rem_init,
  input  logic [wvtp_pkg::REM_W-1:0]   den,
  input  logic [wvtp_pkg::T_BITS-1:0]  low,
  input  logic [4:0]                   steps,
  output logic                         done,
  output logic [wvtp_pkg::T_BITS-1:0]  quo
);
  import wvtp_pkg::*;

  logic              busy;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  den_r;
  logic [T_BITS-1:0] low_r;
  logic [4:0]        cnt;
  logic [REM_W-1:0]  shifted;
  logic              qbit;
  logic [REM_W-1:0]  rem_next;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    shifted  = {rem[REM_W-2:0], low_r[T_BITS-1]};
    qbit     = (shifted >= den_r);
    rem_next = qbit ? shifted - den_r : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= rem_init;
        den_r <= den;
        low_r <= low;
        cnt   <= steps;
        quo   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= rem_next;
        low_r <= {low_r[T_BITS-2:0], 1'b0};
        quo   <= {quo[T_BITS-2:0], qbit};
        cnt   <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/wvtp_store.sv
`timescale 1ns / 1ps

module wvtp_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [wvtp_pkg::IDX_W-1:0]  wr_addr,
  input  logic [95:0]                 wr_data,
  input  logic [wvtp_pkg::IDX_W-1:0]  rd_addr,
  output logic [95:0]                 rd_data
);
  import wvtp_pkg::*;

  // camera-space vertices {x, y, z}
  logic [95:0] mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/wireframe_vertex_transform_project_top.sv
`timescale 1ns / 1ps

// Wireframe vertex transform and edge projection.
// Input stream s_*: tuser is the kind (vertex or edge). A vertex transaction
// is rotated by the object rotation, offset, rotated by the view rotation and
// stored in a 16-entry vertex memory; it produces no output. An edge
// transaction reads two stored vertices, clips against the near plane and
// returns one output transaction on m_*: tuser is the visible flag, tdata the
// two saturated pixel points.
// Sequencing: a vertex keeps the sequencer busy for two rotations of five
// states, four products each on the shared 33x32 multiplier. An edge is
// fetched and tested, then when one end is clipped it takes a 30-step serial
// divide plus two products, then per end three multiplier products and two
// 15-step divides (skipped when the pixel saturates), then the result is
// loaded; an edge fully behind the near plane goes straight to the load.
// s_tready is high only when idle.
// The result sits in an output register; the next item is accepted while it
// waits, and the sequencer holds before loading a new result until the
// receiver takes the old one. Reset (rst, synchronous) loads the register
// defaults and empties the output register; memory is undefined until written.

module wireframe_vertex_transform_project_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // vertex_index[3:0], vertex_x[35:4], vertex_y[67:36], vertex_z[99:68],
  // first_index[103:100], second_index[107:104], zero pad
  input  logic [111:0] s_tdata,
  // kind[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // start_px[15:0], start_py[31:16], end_px[47:32], end_py[63:48]
  output logic [63:0]  m_tdata,
  // visible[0]
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);
  import wvtp_pkg::*;

  typedef enum logic [4:0] {
    IDLE, ROT0, ROT1, ROT2, ROT3, ROT4,
    RD_A, RD_B, LD_B, CHK,
    CLIP_DIV, CLIP_WAIT, CLIP_MX, CLIP_MY, CLIP_END,
    SCR0, SCR1, SCR2, SCR3, DIV_SET, DIV_WAIT, DONE
  } state_t;

  state_t state;

  // configuration
  logic signed [15:0] object_cos, object_sin, view_cos, view_sin;
  logic signed [31:0] offset_x, offset_y, offset_z;

  // item registers
  logic [IDX_W-1:0]   vidx, aidx, bidx;
  logic signed [31:0] rx, ry, rz, tx;
  logic signed [15:0] rc, rs;
  logic               rot2;
  wide_t              acc;
  logic signed [31:0] x1, y1, z1, x2, y2, z2;
  logic               clip_first;
  logic [T_BITS-1:0]  t;
  logic               pt, which, neg, vis;
  logic signed [NUM_W-1:0] numx, numy;
  logic signed [15:0] spx, spy, epx, epy;

  // shared units
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;
  logic               div_start;
  logic [REM_W-1:0]   div_rem, div_den;
  logic [T_BITS-1:0]  div_low;
  logic [4:0]         div_steps;
  logic               div_done;
  logic [T_BITS-1:0]  quo;
  logic [95:0]        rd_data;
  logic               st_we;
  logic [IDX_W-1:0]   rd_addr;

  // datapath helpers
  wide_t              prod_w;
  logic signed [31:0] rot_nx, rot_nz;
  logic signed [31:0] cx, cy, cz;
  logic signed [31:0] bx, by, bz, fx, fy, fz;
  logic signed [33:0] cnum, cden;
  logic signed [31:0] clip_v;
  logic signed [NUM_W-1:0] dnum;
  logic [NUM_W-1:0]   mag;
  logic [35:0]        dden;
  logic               ovf;
  logic signed [15:0] pix_val;
  logic               pix_adv;
  logic signed [31:0] rd_x, rd_y, rd_z;

  wvtp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  wvtp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .rem_init(div_rem), .den(div_den),
    .low(div_low), .steps(div_steps), .done(div_done), .quo(quo)
  );

  wvtp_store u_store (
    .clk(clk), .we(st_we), .wr_addr(vidx), .wr_data({tx, ry, rot_nz}),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign s_tready = (state == IDLE);
  assign st_we    = (state == ROT4) && rot2;
  assign rd_addr  = (state == RD_A) ? aidx : bidx;
  assign rd_x     = rd_data[95:64];
  assign rd_y     = rd_data[63:32];
  assign rd_z     = rd_data[31:0];

  // datapath arithmetic
  always_comb begin
    prod_w = wide_t'(prod);
    rot_nx = sat32((acc - prod_w) >>> 14);
    rot_nz = sat32((acc + prod_w) >>> 14);
    cx = pt ? x2 : x1;
    cy = pt ? y2 : y1;
    cz = pt ? z2 : z1;
    bx = clip_first ? x1 : x2;
    by = clip_first ? y1 : y2;
    bz = clip_first ? z1 : z2;
    fx = clip_first ? x2 : x1;
    fy = clip_first ? y2 : y1;
    fz = clip_first ? z2 : z1;
    cnum = 34'(fz) - 34'(NEAR_Z);
    cden = 34'(fz) - 34'(bz);
    clip_v = 32'(prod >>> T_BITS);
    dnum = which ? numy : numx;
    dden = which ? {3'b000, cz, 1'b0} : {cz, 4'b0000};
    mag  = (dnum < 0) ? NUM_W'(-dnum) : NUM_W'(dnum);
    ovf  = (64'(mag) >= {13'd0, dden, 15'd0});
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ROT0:    begin mul_a = 33'(rx); mul_b = 32'(rc); end
      ROT1:    begin mul_a = 33'(rz); mul_b = 32'(rs); end
      ROT2:    begin mul_a = 33'(rx); mul_b = 32'(rs); end
      ROT3:    begin mul_a = 33'(rz); mul_b = 32'(rc); end
      CLIP_MX: begin mul_a = 33'(bx) - 33'(fx); mul_b = {2'b00, t}; end
      CLIP_MY: begin mul_a = 33'(by) - 33'(fy); mul_b = {2'b00, t}; end
      SCR0:    begin mul_a = 33'(cz); mul_b = W8; end
      SCR1:    begin mul_a = 33'(cx); mul_b = W5; end
      SCR2:    begin mul_a = 33'(cz) - 33'(cy); mul_b = HGT; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // pixel value from a finished division or an overflow
  always_comb begin
    pix_adv = 1'b0;
    pix_val = '0;
    if (state == DIV_SET && ovf) begin
      pix_adv = 1'b1;
      pix_val = (dnum < 0) ? 16'sh8000 : 16'sh7FFF;
    end else if (state == DIV_WAIT && div_done) begin
      pix_adv = 1'b1;
      pix_val = neg ? -$signed({1'b0, quo[PIX_Q-1:0]}) : $signed({1'b0, quo[PIX_Q-1:0]});
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      object_cos <= 16'sd16384;
      object_sin <= 16'sd0;
      view_cos   <= 16'sd16302;
      view_sin   <= 16'sd1636;
      offset_x   <= '0;
      offset_y   <= '0;
      offset_z   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_OBJECT_COS: object_cos <= cfg_data[15:0];
        CFG_OBJECT_SIN: object_sin <= cfg_data[15:0];
        CFG_VIEW_COS:   view_cos   <= cfg_data[15:0];
        CFG_VIEW_SIN:   view_sin   <= cfg_data[15:0];
        CFG_OFFSET_X:   offset_x   <= cfg_data;
        CFG_OFFSET_Y:   offset_y   <= cfg_data;
        CFG_OFFSET_Z:   offset_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      m_tvalid  <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= (state == CLIP_DIV) || (state == DIV_SET && !ovf);
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end
      if (pix_adv) begin
        priority if (!pt && !which) spx <= pix_val;
        else if (!pt)               spy <= pix_val;
        else if (!which)            epx <= pix_val;
        else                        epy <= pix_val;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            vidx <= s_tdata[IDX_W-1:0];
            aidx <= s_tdata[100 +: IDX_W];
            bidx <= s_tdata[104 +: IDX_W];
            rx   <= s_tdata[35:4];
            ry   <= s_tdata[67:36];
            rz   <= s_tdata[99:68];
            rc   <= object_cos;
            rs   <= object_sin;
            rot2 <= 1'b0;
            state <= (s_tuser == KIND_EDGE) ? RD_A : ROT0;
          end
        end
        ROT0: state <= ROT1;
        ROT1: begin
          acc   <= prod_w;
          state <= ROT2;
        end
        ROT2: begin
          tx    <= rot_nx;
          state <= ROT3;
        end
        ROT3: begin
          acc   <= prod_w;
          state <= ROT4;
        end
        ROT4: begin
          if (!rot2) begin
            rx    <= sat32(wide_t'(tx) + wide_t'(offset_x));
            ry    <= sat32(wide_t'(ry) + wide_t'(offset_y));
            rz    <= sat32(wide_t'(rot_nz) + wide_t'(offset_z));
            rc    <= view_cos;
            rs    <= view_sin;
            rot2  <= 1'b1;
            state <= ROT0;
          end else begin
            state <= IDLE;
          end
        end
        RD_A: state <= RD_B;
        RD_B: begin
          x1 <= rd_x;
          y1 <= rd_y;
          z1 <= rd_z;
          state <= LD_B;
        end
        LD_B: begin
          x2 <= rd_x;
          y2 <= rd_y;
          z2 <= rd_z;
          state <= CHK;
        end
        CHK: begin
          pt    <= 1'b0;
          which <= 1'b0;
          vis   <= !(z1 < NEAR_Z && z2 < NEAR_Z);
          priority if (z1 < NEAR_Z && z2 < NEAR_Z) begin
            // edge fully behind the near plane
            spx <= '0;
            spy <= '0;
            epx <= '0;
            epy <= '0;
            state <= DONE;
          end else if (z1 < NEAR_Z) begin
            clip_first <= 1'b1;
            state      <= CLIP_DIV;
          end else if (z2 < NEAR_Z) begin
            clip_first <= 1'b0;
            state      <= CLIP_DIV;
          end else begin
            state <= SCR0;
          end
        end
        CLIP_DIV: begin
          div_rem   <= REM_W'(cnum);
          div_den   <= REM_W'(cden);
          div_low   <= '0;
          div_steps <= 5'(T_BITS);
          state     <= CLIP_WAIT;
        end
        CLIP_WAIT: begin
          if (div_done) begin
            t     <= quo;
            state <= CLIP_MX;
          end
        end
        CLIP_MX: state <= CLIP_MY;
        CLIP_MY: begin
          if (clip_first) x1 <= fx + clip_v;
          else            x2 <= fx + clip_v;
          state <= CLIP_END;
        end
        CLIP_END: begin
          if (clip_first) begin
            y1 <= fy + clip_v;
            z1 <= NEAR_Z;
          end else begin
            y2 <= fy + clip_v;
            z2 <= NEAR_Z;
          end
          state <= SCR0;
        end
        SCR0: state <= SCR1;
        SCR1: begin
          acc   <= prod_w;
          state <= SCR2;
        end
        SCR2: begin
          numx  <= NUM_W'(acc + prod_w);
          state <= SCR3;
        end
        SCR3: begin
          numy  <= NUM_W'(prod);
          which <= 1'b0;
          state <= DIV_SET;
        end
        DIV_SET: begin
          neg <= (dnum < 0);
          if (ovf) begin
            priority if (!which) begin
              which <= 1'b1;
            end else if (!pt) begin
              pt    <= 1'b1;
              state <= SCR0;
            end else begin
              state <= DONE;
            end
          end else begin
            div_rem   <= REM_W'(mag >> PIX_Q);
            div_den   <= REM_W'(dden);
            div_low   <= {mag[PIX_Q-1:0], {(T_BITS-PIX_Q){1'b0}}};
            div_steps <= 5'(PIX_Q);
            state     <= DIV_WAIT;
          end
        end
        DIV_WAIT: begin
          if (div_done) begin
            priority if (!which) begin
              which <= 1'b1;
              state <= DIV_SET;
            end else if (!pt) begin
              pt    <= 1'b1;
              state <= SCR0;
            end else begin
              state <= DONE;
            end
          end
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= vis;
            m_tdata  <= {epy, epx, spy, spx};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
